@@ rtl/mvc_pkg.sv @@
// ----------------------------------------------------------------------------
// MAVLink v1 CRC check package
// Shared constants, the result type, the CRC-16 byte update and the CRC extra
// table used by the frame checksum checker.
// ----------------------------------------------------------------------------
package mvc_pkg;

  localparam int unsigned HeaderBytes = 6;
  localparam int unsigned PosWidth    = 9;
  localparam logic [15:0] CrcInit     = 16'hFFFF;

  typedef struct packed {
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
    logic        crc_ok;
    logic [7:0]  msg_id;
    logic [7:0]  payload_length;
  } result_t;

  localparam logic [7:0] CrcExtraTable [256] = '{
    8'd50,  8'd124, 8'd137, 8'd0,   8'd237, 8'd217, 8'd104, 8'd119, 8'd0,   8'd0,
    8'd0,   8'd89,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd214, 8'd159, 8'd220, 8'd168, 8'd24,  8'd23,  8'd170, 8'd144, 8'd67,  8'd115,
    8'd39,  8'd246, 8'd185, 8'd104, 8'd237, 8'd244, 8'd222, 8'd212, 8'd9,   8'd254,
    8'd230, 8'd28,  8'd28,  8'd132, 8'd221, 8'd232, 8'd11,  8'd153, 8'd41,  8'd39,
    8'd214, 8'd223, 8'd141, 8'd33,  8'd15,  8'd3,   8'd100, 8'd24,  8'd239, 8'd238,
    8'd30,  8'd200, 8'd183, 8'd0,   8'd130, 8'd0,   8'd148, 8'd21,  8'd0,   8'd52,
    8'd124, 8'd0,   8'd0,   8'd0,   8'd20,  8'd0,   8'd152, 8'd143, 8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd231,
    8'd183, 8'd63,  8'd54,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd175, 8'd102, 8'd158, 8'd208, 8'd56,  8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd204,
    8'd49,  8'd170, 8'd44,  8'd83,  8'd46,  8'd0
  };

  // X.25 (MCRF4XX) CRC-16 update by one byte.
  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [7:0] t;
    t = b ^ crc[7:0];
    t = t ^ {t[3:0], 4'b0000};
    return {8'h00, crc[15:8]} ^ {t, 8'h00} ^ {5'b00000, t, 3'b000} ^ {12'h000, t[7:4]};
  endfunction

endpackage

@@ rtl/mvc_if.sv @@
// ----------------------------------------------------------------------------
// MAVLink v1 CRC check channels
// Valid/ready channels for incoming frame bytes and for checksum results.
// ----------------------------------------------------------------------------
interface mvc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_first;

  modport source (output valid, frame_byte, frame_first, input ready);
  modport sink (input valid, frame_byte, frame_first, output ready);
endinterface

interface mvc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] computed_crc;
  logic [15:0] received_crc;
  logic        crc_ok;
  logic [7:0]  msg_id;
  logic [7:0]  payload_length;

  modport source (output valid, computed_crc, received_crc, crc_ok, msg_id,
                  payload_length, input ready);
  modport sink (input valid, computed_crc, received_crc, crc_ok, msg_id,
                payload_length, output ready);
endinterface

@@ rtl/mvc_frame_tracker.sv @@
// ----------------------------------------------------------------------------
// MAVLink v1 frame tracker
// Holds the frame position, header fields and running CRC, and folds one
// byte per step into them. Flags the step that completes a frame.
// ----------------------------------------------------------------------------
module mvc_frame_tracker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_i,
  input  logic [7:0]      frame_byte_i,
  input  logic            frame_first_i,
  output logic            done_o,
  output mvc_pkg::result_t result_o
);
  import mvc_pkg::*;

  logic [15:0]         crc_q, crc_d;
  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          len_q, len_d;
  logic [7:0]          id_q, id_d;
  logic [7:0]          crc_low_q, crc_low_d;
  logic                in_frame_q, in_frame_d;
  logic [PosWidth-1:0] low_pos;
  logic [15:0]         rx_crc;

  assign low_pos = PosWidth'(HeaderBytes) + {1'b0, len_q};
  assign rx_crc  = {frame_byte_i, crc_low_q};

  assign done_o = !frame_first_i && in_frame_q && (pos_q > low_pos);

  assign result_o.computed_crc   = crc_q;
  assign result_o.received_crc   = rx_crc;
  assign result_o.crc_ok         = (crc_q == rx_crc);
  assign result_o.msg_id         = id_q;
  assign result_o.payload_length = len_q;

  always_comb begin
    crc_d      = crc_q;
    pos_d      = pos_q;
    len_d      = len_q;
    id_d       = id_q;
    crc_low_d  = crc_low_q;
    in_frame_d = in_frame_q;
    if (step_i) begin
      if (frame_first_i) begin
        crc_d      = CrcInit;
        pos_d      = PosWidth'(1);
        in_frame_d = 1'b1;
      end else if (in_frame_q) begin
        if (pos_q < PosWidth'(HeaderBytes)) begin
          if (pos_q == PosWidth'(1)) begin
            len_d = frame_byte_i;
          end
          if (pos_q == PosWidth'(HeaderBytes - 1)) begin
            id_d = frame_byte_i;
          end
          crc_d = crc_byte(crc_q, frame_byte_i);
          pos_d = pos_q + PosWidth'(1);
        end else if (pos_q < low_pos) begin
          crc_d = crc_byte(crc_q, frame_byte_i);
          pos_d = pos_q + PosWidth'(1);
        end else if (pos_q == low_pos) begin
          crc_low_d = frame_byte_i;
          crc_d     = crc_byte(crc_q, CrcExtraTable[id_q]);
          pos_d     = pos_q + PosWidth'(1);
        end else begin
          in_frame_d = 1'b0;
          pos_d      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q      <= CrcInit;
      pos_q      <= '0;
      len_q      <= '0;
      id_q       <= '0;
      crc_low_q  <= '0;
      in_frame_q <= 1'b0;
    end else begin
      crc_q      <= crc_d;
      pos_q      <= pos_d;
      len_q      <= len_d;
      id_q       <= id_d;
      crc_low_q  <= crc_low_d;
      in_frame_q <= in_frame_d;
    end
  end

  a_idle_pos_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q |-> pos_q == '0)
    else $error("Frame position is not zero while idle.");

  a_pos_bounded : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_frame_q |-> pos_q <= low_pos + PosWidth'(1))
    else $error("Frame position ran past the checksum bytes.");

  a_done_ends_frame : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && done_o |=> !in_frame_q && pos_q == '0)
    else $error("A completed frame did not return to idle.");

endmodule

@@ rtl/mavlink_v1_frame_crc_check_core.sv @@
// ----------------------------------------------------------------------------
// MAVLink v1 frame CRC check core
// Checks the X.25 checksum with CRC extra of MAVLink v1 frames, byte by byte.
// ----------------------------------------------------------------------------
// The block takes one frame byte per clock cycle unless stalled, and emits one
// item on the second checksum byte of each frame, carrying the computed and
// received checksums, a match flag, the message ID and the payload length.
// A byte is held in an input register, folded into the frame state by the
// combinational CRC byte update, and a completed frame's result lands in the
// output register. The result register lets the next bytes flow in while a
// result waits; input stalls only when a result is waiting and another frame
// completes.
module mavlink_v1_frame_crc_check_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  mvc_byte_if.sink     frame_i,
  mvc_result_if.source result_o
);
  import mvc_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       out_valid_q;
  result_t    out_q;
  result_t    trk_result;
  logic       trk_done;
  logic       out_free;
  logic       consume;

  assign out_free      = !out_valid_q || result_o.ready;
  assign consume       = in_valid_q && (!trk_done || out_free);
  assign frame_i.ready = !in_valid_q || consume;

  mvc_frame_tracker u_tracker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (consume),
    .frame_byte_i  (in_byte_q),
    .frame_first_i (in_first_q),
    .done_o        (trk_done),
    .result_o      (trk_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (frame_i.ready) begin
      in_valid_q <= frame_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (frame_i.ready && frame_i.valid) begin
      in_byte_q  <= frame_i.frame_byte;
      in_first_q <= frame_i.frame_first;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= consume && trk_done;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && trk_done) begin
      out_q <= trk_result;
    end
  end

  assign result_o.valid          = out_valid_q;
  assign result_o.computed_crc   = out_q.computed_crc;
  assign result_o.received_crc   = out_q.received_crc;
  assign result_o.crc_ok         = out_q.crc_ok;
  assign result_o.msg_id         = out_q.msg_id;
  assign result_o.payload_length = out_q.payload_length;

  a_done_loads_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    consume && trk_done |=> out_valid_q)
    else $error("A completed frame did not produce a result item.");

  a_ok_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.crc_ok == (out_q.computed_crc == out_q.received_crc))
    else $error("Match flag disagrees with the checksums.");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_o.ready |-> !(consume && trk_done))
    else $error("A waiting result item was overwritten.");

endmodule
